>>> rtl/csc_pkg.sv
// Shared widths, types and codes for the cloth spring constraint unit.
package csc_pkg;
	localparam int CW     = 32;
	localparam int MAG_W  = CW + 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int ROOT_W = MAG_W;
	localparam int REM_W  = ROOT_W + 2;
	localparam int QB     = CW + 2;
	localparam int DIV_W  = CW;
	localparam int NUM_W  = SQ_W + 1;
	localparam int SUM_W  = CW + 3;

	typedef enum logic [1:0] {
		OC_NONE = 2'd0,
		OC_CORR = 2'd1,
		OC_SKIP = 2'd2
	} outcome_t;

	typedef struct packed {
		logic signed [CW-1:0] px;
		logic signed [CW-1:0] py;
		logic signed [CW-1:0] nx;
		logic signed [CW-1:0] ny;
		logic [CW-2:0]        rest;
		logic                 neg_x;
		logic                 neg_y;
		logic [MAG_W-1:0]     mag_x;
		logic [MAG_W-1:0]     mag_y;
	} ctx_t;

	typedef struct packed {
		ctx_t              ctx;
		logic [SQ_W-1:0]   rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_t;

	typedef struct packed {
		ctx_t             ctx;
		logic             skip;
		logic             stretched;
		logic [CW-1:0]    dv;
		logic             ovf_x;
		logic             ovf_y;
		logic [DIV_W-1:0] rem_x;
		logic [DIV_W-1:0] rem_y;
		logic [QB-1:0]    nl_x;
		logic [QB-1:0]    nl_y;
		logic [QB-1:0]    q_x;
		logic [QB-1:0]    q_y;
	} div_t;
endpackage

>>> rtl/csc_sqrt_cell.sv
// One digit stage of the pipelined integer square root.
module csc_sqrt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  csc_pkg::sqrt_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output csc_pkg::sqrt_t out_data
);
	import csc_pkg::*;

	logic              v_q;
	sqrt_t             d_q;
	sqrt_t             nxt;
	logic [REM_W:0]    r2;
	logic [REM_W:0]    t;

	always_comb begin
		nxt = in_data;
		r2 = {in_data.rem[REM_W-2:0], in_data.rad[SQ_W-1:SQ_W-2]};
		t = {1'b0, in_data.root, 2'b01};
		nxt.rad = {in_data.rad[SQ_W-3:0], 2'b00};
		if (r2 >= t) begin
			nxt.rem = REM_W'(r2 - t);
			nxt.root = {in_data.root[ROOT_W-2:0], 1'b1};
		end else begin
			nxt.rem = REM_W'(r2);
			nxt.root = {in_data.root[ROOT_W-2:0], 1'b0};
		end
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data = d_q;
endmodule

>>> rtl/csc_div_cell.sv
// One quotient-bit stage of the pipelined restoring dividers for both axes.
module csc_div_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  csc_pkg::div_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output csc_pkg::div_t out_data
);
	import csc_pkg::*;

	logic           v_q;
	div_t           d_q;
	div_t           nxt;
	logic [DIV_W:0] rx;
	logic [DIV_W:0] ry;
	logic [DIV_W:0] dz;
	logic           gx;
	logic           gy;

	always_comb begin
		nxt = in_data;
		dz = {1'b0, in_data.dv};
		rx = {in_data.rem_x, in_data.nl_x[QB-1]};
		ry = {in_data.rem_y, in_data.nl_y[QB-1]};
		gx = rx >= dz;
		gy = ry >= dz;
		nxt.rem_x = gx ? DIV_W'(rx - dz) : DIV_W'(rx);
		nxt.rem_y = gy ? DIV_W'(ry - dz) : DIV_W'(ry);
		nxt.nl_x = {in_data.nl_x[QB-2:0], 1'b0};
		nxt.nl_y = {in_data.nl_y[QB-2:0], 1'b0};
		nxt.q_x = {in_data.q_x[QB-2:0], gx};
		nxt.q_y = {in_data.q_y[QB-2:0], gy};
	end

	assign in_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_q <= nxt;
		end
	end

	assign out_valid = v_q;
	assign out_data = d_q;
endmodule

>>> rtl/cloth_spring_constraint_unit.sv
// Top level: spring distance constraint, square root and divider cell chains.
//
//  channel | dir | payload
//  s_*     | in  | point, neighbour, rest length
//  m_*     | out | corrected coordinates, outcome, saturated
//
// One spring per cycle sustained while m_tready stays high; pipeline of 3 + 33 sqrt
// cells + 3 + 34 divider cells + 1 output stage. Every stage has its own valid bit, so
// bubbles close up under back-pressure. Reset clears only valid bits.
module cloth_spring_constraint_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [159:0] s_tdata,  // point_x, point_y, neighbour_x, neighbour_y, rest_length, pad
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [127:0] m_tdata,  // new_point_x, new_point_y, new_neighbour_x, new_neighbour_y
	output logic [2:0]   m_tuser   // outcome, saturated
);
	import csc_pkg::*;

	// stage 1: differences
	logic v_s1, r_s1;
	ctx_t c_s1, c_in;
	logic signed [MAG_W-1:0] dx, dy;

	always_comb begin
		c_in.px = s_tdata[31:0];
		c_in.py = s_tdata[63:32];
		c_in.nx = s_tdata[95:64];
		c_in.ny = s_tdata[127:96];
		c_in.rest = s_tdata[158:128];
		dx = MAG_W'(c_in.nx) - MAG_W'(c_in.px);
		dy = MAG_W'(c_in.ny) - MAG_W'(c_in.py);
		c_in.neg_x = dx[MAG_W-1];
		c_in.neg_y = dy[MAG_W-1];
		c_in.mag_x = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
		c_in.mag_y = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
	end

	// stage 2: squares
	logic v_s2, r_s2;
	ctx_t c_s2;
	logic [SQ_W-1:0] sqx_s2, sqy_s2;
	// stage 3: sum of squares
	logic v_s3, r_s3;
	ctx_t c_s3;
	logic [SQ_W-1:0] ss_s3;

	assign s_tready = r_s1;
	assign r_s1 = !v_s1 || r_s2;
	assign r_s2 = !v_s2 || r_s3;

	logic  sq_v [0:ROOT_W];
	logic  sq_r [0:ROOT_W];
	sqrt_t sq_d [0:ROOT_W];

	assign r_s3 = !v_s3 || sq_r[0];
	assign sq_v[0] = v_s3;
	assign sq_d[0] = '{ctx: c_s3, rad: ss_s3, rem: '0, root: '0};

	genvar k;
	generate
		for (k = 0; k < ROOT_W; k++) begin : g_sqrt
			csc_sqrt_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_valid(sq_v[k]), .in_ready(sq_r[k]), .in_data(sq_d[k]),
				.out_valid(sq_v[k+1]), .out_ready(sq_r[k+1]), .out_data(sq_d[k+1])
			);
		end
	endgenerate

	// stage 4: compare with rest length
	logic v_s4, r_s4;
	ctx_t c_s4;
	logic skip_s4, str_s4;
	logic [ROOT_W-1:0] exc_s4;
	// stage 5: numerators
	logic v_s5, r_s5;
	ctx_t c_s5;
	logic skip_s5, str_s5;
	logic [SQ_W-1:0] numx_s5, numy_s5;
	// stage 6: rounding offset, divisor, overflow
	logic v_s6, r_s6;
	div_t d_s6, d6n;
	logic [NUM_W-1:0] fx, fy;

	assign sq_r[ROOT_W] = r_s4;
	assign r_s4 = !v_s4 || r_s5;
	assign r_s5 = !v_s5 || r_s6;

	always_comb begin
		d6n = '0;
		d6n.ctx = c_s5;
		d6n.skip = skip_s5;
		d6n.stretched = str_s5;
		d6n.dv = {c_s5.rest, 1'b0};
		fx = NUM_W'(numx_s5) + NUM_W'(c_s5.rest);
		fy = NUM_W'(numy_s5) + NUM_W'(c_s5.rest);
		d6n.ovf_x = fx[NUM_W-1:QB] >= (NUM_W-QB)'(d6n.dv);
		d6n.ovf_y = fy[NUM_W-1:QB] >= (NUM_W-QB)'(d6n.dv);
		d6n.rem_x = DIV_W'(fx[NUM_W-1:QB]);
		d6n.rem_y = DIV_W'(fy[NUM_W-1:QB]);
		d6n.nl_x = fx[QB-1:0];
		d6n.nl_y = fy[QB-1:0];
	end

	logic dv_v [0:QB];
	logic dv_r [0:QB];
	div_t dv_d [0:QB];

	assign r_s6 = !v_s6 || dv_r[0];
	assign dv_v[0] = v_s6;
	assign dv_d[0] = d_s6;

	generate
		for (k = 0; k < QB; k++) begin : g_div
			csc_div_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.in_valid(dv_v[k]), .in_ready(dv_r[k]), .in_data(dv_d[k]),
				.out_valid(dv_v[k+1]), .out_ready(dv_r[k+1]), .out_data(dv_d[k+1])
			);
		end
	endgenerate

	// stage 7: apply, clamp, output
	logic v_s7, r_s7;
	logic [127:0] dat_s7;
	logic [2:0] usr_s7;
	div_t df;
	logic [QB-1:0] cx, cy;
	logic signed [SUM_W-1:0] npx, npy, nnx, nny;
	logic signed [CW-1:0] opx, opy, onx, ony;
	logic sat;
	outcome_t oc;
	localparam logic [QB-1:0] CAP = QB'(1) << (CW + 1);
	localparam logic signed [SUM_W-1:0] CMAX = SUM_W'((64'd1 << (CW - 1)) - 64'd1);
	localparam logic signed [SUM_W-1:0] CMIN = -SUM_W'(64'd1 << (CW - 1));

	function automatic logic signed [CW-1:0] clip(input logic signed [SUM_W-1:0] v,
		output logic s);
		logic signed [CW-1:0] o;
		s = 1'b0;
		o = CW'(v);
		if (v > CMAX) begin
			s = 1'b1;
			o = CW'(CMAX);
		end else if (v < CMIN) begin
			s = 1'b1;
			o = CW'(CMIN);
		end
		return o;
	endfunction

	logic s0, s1, s2, s3;

	always_comb begin
		df = dv_d[QB];
		cx = (df.ovf_x || df.q_x > CAP) ? CAP : df.q_x;
		cy = (df.ovf_y || df.q_y > CAP) ? CAP : df.q_y;
		npx = df.ctx.neg_x ? SUM_W'(df.ctx.px) - SUM_W'(cx) : SUM_W'(df.ctx.px) + SUM_W'(cx);
		nnx = df.ctx.neg_x ? SUM_W'(df.ctx.nx) + SUM_W'(cx) : SUM_W'(df.ctx.nx) - SUM_W'(cx);
		npy = df.ctx.neg_y ? SUM_W'(df.ctx.py) - SUM_W'(cy) : SUM_W'(df.ctx.py) + SUM_W'(cy);
		nny = df.ctx.neg_y ? SUM_W'(df.ctx.ny) + SUM_W'(cy) : SUM_W'(df.ctx.ny) - SUM_W'(cy);
		opx = clip(npx, s0);
		opy = clip(npy, s1);
		onx = clip(nnx, s2);
		ony = clip(nny, s3);
		sat = 1'b0;
		if (df.skip) begin
			oc = OC_SKIP;
			opx = df.ctx.px; opy = df.ctx.py; onx = df.ctx.nx; ony = df.ctx.ny;
		end else if (df.stretched) begin
			oc = OC_CORR;
			sat = s0 | s1 | s2 | s3;
		end else begin
			oc = OC_NONE;
			opx = df.ctx.px; opy = df.ctx.py; onx = df.ctx.nx; ony = df.ctx.ny;
		end
	end

	assign dv_r[QB] = r_s7;
	assign r_s7 = !v_s7 || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (r_s1) v_s1 <= s_tvalid;
			if (r_s2) v_s2 <= v_s1;
			if (r_s3) v_s3 <= v_s2;
			if (r_s4) v_s4 <= sq_v[ROOT_W];
			if (r_s5) v_s5 <= v_s4;
			if (r_s6) v_s6 <= v_s5;
			if (r_s7) v_s7 <= dv_v[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (r_s1 && s_tvalid) begin
			c_s1 <= c_in;
		end
		if (r_s2 && v_s1) begin
			c_s2 <= c_s1;
			sqx_s2 <= SQ_W'(c_s1.mag_x * c_s1.mag_x);
			sqy_s2 <= SQ_W'(c_s1.mag_y * c_s1.mag_y);
		end
		if (r_s3 && v_s2) begin
			c_s3 <= c_s2;
			ss_s3 <= sqx_s2 + sqy_s2;
		end
		if (r_s4 && sq_v[ROOT_W]) begin
			c_s4 <= sq_d[ROOT_W].ctx;
			skip_s4 <= sq_d[ROOT_W].ctx.rest == '0;
			str_s4 <= sq_d[ROOT_W].root > ROOT_W'(sq_d[ROOT_W].ctx.rest);
			exc_s4 <= sq_d[ROOT_W].root - ROOT_W'(sq_d[ROOT_W].ctx.rest);
		end
		if (r_s5 && v_s4) begin
			c_s5 <= c_s4;
			skip_s5 <= skip_s4;
			str_s5 <= str_s4;
			numx_s5 <= SQ_W'(c_s4.mag_x * exc_s4);
			numy_s5 <= SQ_W'(c_s4.mag_y * exc_s4);
		end
		if (r_s6 && v_s5) begin
			d_s6 <= d6n;
		end
		if (r_s7 && dv_v[QB]) begin
			dat_s7 <= {ony, onx, opy, opx};
			usr_s7 <= {sat, oc};
		end
	end

	assign m_tvalid = v_s7;
	assign m_tdata = dat_s7;
	assign m_tuser = usr_s7;
endmodule

>>> test/tb_spring_checker.sv
`timescale 1ns / 100ps
// Checker: watches both stream channels, predicts spring corrections and compares.
module tb_spring_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [159:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [127:0] m_tdata,
	input  logic [2:0]   m_tuser,
	output int           fail_count,
	output int           pending,
	output int           n_corr,
	output int           n_sat,
	output int           n_skip
);
	import csc_pkg::*;

	typedef struct packed {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] nx;
		logic [31:0] ny;
		outcome_t    oc;
		logic        sat;
	} spring_res_t;

	spring_res_t expected_springs[$];

	function automatic logic [63:0] isqrt(logic [127:0] s);
		logic [63:0] r;
		logic [63:0] t;
		r = '0;
		for (int b = 49; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (128'(t) * 128'(t) <= s)
				r = t;
		end
		return r;
	endfunction

	function automatic logic signed [63:0] corr_amount(logic signed [63:0] d,
			logic [63:0] excess, logic [63:0] rest);
		logic [127:0] mag;
		logic [127:0] q;
		logic [63:0]  c;
		mag = (d < 0) ? 128'(-d) : 128'(d);
		q = (mag * 128'(excess) + 128'(rest)) / (128'(rest) * 2);
		c = (q > 128'(64'd1 << 33)) ? (64'd1 << 33) : q[63:0];
		return (d < 0) ? -$signed(c) : $signed(c);
	endfunction

	function automatic logic [31:0] clamp32(logic signed [63:0] v, inout logic sat);
		if (v > 64'sd2147483647) begin
			sat = 1'b1;
			return 32'h7fffffff;
		end
		if (v < -64'sd2147483648) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic spring_res_t predict_spring(logic [159:0] d);
		spring_res_t r;
		logic signed [63:0] px, py, nx, ny, dx, dy, cx, cy;
		logic [63:0] rest, root_dist;
		logic [127:0] s;
		logic sat;
		px = 64'($signed(d[31:0]));
		py = 64'($signed(d[63:32]));
		nx = 64'($signed(d[95:64]));
		ny = 64'($signed(d[127:96]));
		rest = 64'(d[158:128]);
		sat = 1'b0;
		r.px = d[31:0];
		r.py = d[63:32];
		r.nx = d[95:64];
		r.ny = d[127:96];
		r.oc = OC_NONE;
		if (rest == 0) begin
			r.oc = OC_SKIP;
		end else begin
			dx = nx - px;
			dy = ny - py;
			s = 128'(dx * dx) + 128'(dy * dy);
			root_dist = isqrt(s);
			if (root_dist > rest) begin
				cx = corr_amount(dx, root_dist - rest, rest);
				cy = corr_amount(dy, root_dist - rest, rest);
				r.px = clamp32(px + cx, sat);
				r.py = clamp32(py + cy, sat);
				r.nx = clamp32(nx - cx, sat);
				r.ny = clamp32(ny - cy, sat);
				r.oc = OC_CORR;
			end
		end
		r.sat = sat;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		spring_res_t e;
		spring_res_t a;
		if (!arst_n) begin
			fail_count <= 0;
			pending <= 0;
			n_corr <= 0;
			n_sat <= 0;
			n_skip <= 0;
		end else begin
			if (s_tvalid && s_tready)
				expected_springs.push_back(predict_spring(s_tdata));
			if (m_tvalid && m_tready) begin
				a = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
					outcome_t'(m_tuser[1:0]), m_tuser[2]};
				if (expected_springs.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("%0t: unexpected transfer %h", $realtime, a);
				end else begin
					e = expected_springs.pop_front();
					if (e.oc == OC_CORR)
						n_corr <= n_corr + 1;
					if (e.oc == OC_SKIP)
						n_skip <= n_skip + 1;
					if (e.sat)
						n_sat <= n_sat + 1;
					if (a !== e) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display({"%0t: exp px %h py %h nx %h ny %h oc %0d sat %b",
								" | act px %h py %h nx %h ny %h oc %0d sat %b"},
								$realtime, e.px, e.py, e.nx, e.ny, e.oc, e.sat,
								a.px, a.py, a.nx, a.ny, a.oc, a.sat);
					end
				end
			end
			pending <= expected_springs.size();
		end
	end
endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top: spring stimulus, idling and back-pressure, verdict.
module tb_top;
	import csc_pkg::*;

	localparam int LATENCY = 74;
	localparam int N_RANDOM = 1400;
	localparam int CYCLE_LIMIT = 200000;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [159:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [127:0] m_tdata;
	logic [2:0]   m_tuser;
	int           fail_count, pending, n_corr, n_sat, n_skip;
	int           cycle_count;
	bit           calm;
	bit           hold_sink;
	int           n_sent;

	cloth_spring_constraint_unit dut (.*);

	tb_spring_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("cloth_spring_constraint_unit: mismatch");
				$finish;
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_sink)
				m_tready <= 1'b0;
			else
				m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
		end
	end

	// Long receiver hold-off while the sender keeps offering.
	initial begin
		hold_sink = 1'b0;
		wait (n_sent == 300);
		@(posedge clk);
		hold_sink = 1'b1;
		repeat (400) @(posedge clk);
		hold_sink = 1'b0;
	end

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(4000)) - 2000) << 16;
			2: return $urandom_range(1) ? 32'h7fffffff - $urandom_range(3)
				: 32'h80000000 + $urandom_range(3);
			default: return 32'($signed($urandom_range(200000)) - 100000);
		endcase
	endfunction

	task automatic send_spring(logic [31:0] px, logic [31:0] py, logic [31:0] nx,
			logic [31:0] ny, logic [30:0] rest);
		if (!calm)
			while ($urandom_range(99) < 37) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, rest, ny, nx, py, px};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_sent++;
	endtask

	task automatic send_random;
		int m;
		logic [31:0] px, py;
		logic [30:0] rest;
		m = $urandom_range(3);
		px = rand_coord(m);
		py = rand_coord(m);
		case ($urandom_range(5))
			0: rest = 31'($urandom());
			1: rest = '0;
			2: rest = 31'($urandom_range(3));
			3: rest = 31'(31'h7fffffff - $urandom_range(2));
			default: rest = 31'($urandom_range(1 << 20));
		endcase
		if ($urandom_range(2) == 0)
			send_spring(px, py, rand_coord($urandom_range(3)), rand_coord($urandom_range(3)),
				rest);
		else
			send_spring(px, py, px + rand_coord(3), py + rand_coord(3), rest);
	endtask

	initial begin
		calm = 1'b0;
		n_sent = 0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		send_spring(0, 0, 32'h00030000, 32'h00040000, 31'h00010000);
		send_spring(0, 0, 32'h00030000, 32'h00040000, 31'h00050000);
		send_spring(0, 0, 32'h00030000, 32'h00040000, 31'h00060000);
		send_spring(5, 7, 9, 11, 0);
		send_spring(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 1);
		send_spring(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 1);
		send_spring(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 31'h7fffffff);
		send_spring(32'h80000000, 0, 32'h7fffffff, 0, 31'h7fffffff);
		send_spring(32'hffffffff, 32'hffffffff, 0, 0, 1);
		send_spring(3, 0, 0, 0, 1);
		send_spring(0, 0, 0, 0, 1);
		send_spring(0, 0, 0, 0, 0);
		send_spring(32'h12345678, 32'h9abcdef0, 32'hfedcba98, 32'h76543210, 31'h55555555);
		send_spring(0, 0, 5, 0, 2);
		send_spring(0, 0, 0, 32'hfffffffa, 4);
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == 400)
				calm = 1'b1;
			if (i == 600)
				calm = 1'b0;
			if (i == 900) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				wait (pending == 0);
				@(posedge clk);
			end
			send_random();
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		$display("springs sent %0d: corrected %0d, saturated %0d, zero rest %0d",
			n_sent, n_corr, n_sat, n_skip);
		if (fail_count == 0 && pending == 0)
			$display("cloth_spring_constraint_unit: match");
		else
			$display("cloth_spring_constraint_unit: mismatch");
		$finish;
	end
endmodule
